[hw/rtl/slm_pkg.sv]
// Package for the sorted list merge block: word types, opcodes, command and
// state encodings shared by the front, the command queue, the back and the checker.
// Depends on nothing.
package slm_pkg;

    // Default store depth and command queue depth (the queue depth is a power of two).
    localparam int unsigned LIST_DEPTH_DEF = 32;
    localparam int unsigned CMD_DEPTH      = 4;
    localparam int unsigned VALUE_W        = 32;

    // Opcodes carried on the input word.
    localparam logic [1:0] OP_PUSH_FIRST  = 2'd0;
    localparam logic [1:0] OP_PUSH_SECOND = 2'd1;
    localparam logic [1:0] OP_MERGE       = 2'd2;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    // Input word.
    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [VALUE_W-1:0]  value;
    } item_t;

    // Result word.
    typedef struct packed {
        logic signed [VALUE_W-1:0]  merged_value;
        logic                       last;
        logic                       empty_res;
    } result_t;

    // Commands passed from the front to the back.
    typedef enum logic [1:0] {
        CMD_PUSH_FIRST,
        CMD_PUSH_SECOND,
        CMD_MERGE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MERGE,
        BK_EMPTY
    } back_state_t;

endpackage

[hw/rtl/slm_front.sv]
// Front of the sorted list merge block: accepts input words and classifies them
// into commands for the command queue. Unused opcodes are taken and discarded.
// Depends on slm_pkg.
module slm_front
    import slm_pkg::*;
(
    input  logic  push,
    input  item_t item,
    input  logic  q_full,
    output logic  full,
    output logic  q_push,
    output cmd_t  q_cmd
);

    // Opcode decode; an unused opcode is accepted but never queued.
    always_comb
    begin
        full        = q_full;
        q_push      = 1'b0;
        q_cmd.kind  = CMD_MERGE;
        q_cmd.value = item.value;
        unique case (item.opcode)
            OP_PUSH_FIRST:
            begin
                q_cmd.kind = CMD_PUSH_FIRST;
                q_push     = push && !q_full;
            end
            OP_PUSH_SECOND:
            begin
                q_cmd.kind = CMD_PUSH_SECOND;
                q_push     = push && !q_full;
            end
            OP_MERGE:
            begin
                q_cmd.kind = CMD_MERGE;
                q_push     = push && !q_full;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/slm_cmd_fifo.sv]
// Command queue of the sorted list merge block: a short first-in first-out
// buffer that decouples the front from the back.
// Depends on slm_pkg.
module slm_cmd_fifo
    import slm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output logic valid,
    output cmd_t head
);

    localparam int unsigned PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

    cmd_t          slot_reg [CMD_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_wr, do_rd;

    // Status and head of queue.
    assign full  = (count_reg == (PW+1)'(CMD_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && valid;

    // Pointer and fill count update; the depth is a power of two so pointers wrap.
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[hw/rtl/slm_back.sv]
// Back of the sorted list merge block: the two list stores, their fill counts,
// the merge sequencer and the result register. Depends on slm_pkg.
module slm_back
    import slm_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd_head,
    output logic    cmd_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

    // List stores, read through registered ports.
    logic signed [VALUE_W-1:0] mem_a [LIST_DEPTH];
    logic signed [VALUE_W-1:0] mem_b [LIST_DEPTH];
    logic signed [VALUE_W-1:0] rd_a_reg, rd_b_reg;

    back_state_t   state_reg, state_next;
    logic [CW-1:0] ca_reg, ca_next;
    logic [CW-1:0] cb_reg, cb_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [AW-1:0] addr_a, addr_b;
    logic          wr_a, wr_b;

    result_t       out_reg, prod_word;
    logic          out_valid_reg;
    logic          produce, slot_free;

    logic          a_left, b_left, take_first, is_last;
    logic [CW:0]   pos_sum, total;

    assign slot_free = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    // Merge decision on the current heads of both lists.
    assign a_left     = (i_reg < ca_reg);
    assign b_left     = (j_reg < cb_reg);
    assign take_first = a_left && (!b_left || (rd_a_reg < rd_b_reg));
    assign pos_sum    = {1'b0, i_reg} + {1'b0, j_reg} + (CW+1)'(1);
    assign total      = {1'b0, ca_reg} + {1'b0, cb_reg};
    assign is_last    = (pos_sum == total);

    // Sequencer: pushes, merge setup in idle, one element per free cycle in merge.
    always_comb
    begin
        state_next = state_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd_pop    = 1'b0;
        wr_a       = 1'b0;
        wr_b       = 1'b0;
        produce    = 1'b0;
        prod_word  = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd_head.kind)
                        CMD_PUSH_FIRST:
                        begin
                            if (ca_reg < CW'(LIST_DEPTH))
                            begin
                                wr_a    = 1'b1;
                                ca_next = ca_reg + 1'b1;
                            end
                        end
                        CMD_PUSH_SECOND:
                        begin
                            if (cb_reg < CW'(LIST_DEPTH))
                            begin
                                wr_b    = 1'b1;
                                cb_next = cb_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            i_next = '0;
                            j_next = '0;
                            if ((ca_reg == '0) && (cb_reg == '0))
                            begin
                                state_next = BK_EMPTY;
                            end
                            else
                            begin
                                state_next = BK_MERGE;
                            end
                        end
                    endcase
                end
            end
            BK_EMPTY:
            begin
                if (slot_free)
                begin
                    produce             = 1'b1;
                    prod_word.last      = 1'b1;
                    prod_word.empty_res = 1'b1;
                    state_next          = BK_IDLE;
                end
            end
            BK_MERGE:
            begin
                if (slot_free)
                begin
                    produce = 1'b1;
                    prod_word.merged_value = take_first ? rd_a_reg : rd_b_reg;
                    prod_word.last         = is_last;
                    if (take_first)
                    begin
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    if (is_last)
                    begin
                        ca_next    = '0;
                        cb_next    = '0;
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Read addresses follow the next head indexes; past the end they park at zero.
    assign addr_a = (i_next < CW'(LIST_DEPTH)) ? i_next[AW-1:0] : '0;
    assign addr_b = (j_next < CW'(LIST_DEPTH)) ? j_next[AW-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            ca_reg        <= '0;
            cb_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ca_reg    <= ca_next;
            cb_reg    <= cb_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register holds the oldest waiting word.
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_reg <= prod_word;
        end
    end

    // Store writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[ca_reg[AW-1:0]] <= cmd_head.value;
        end
        if (wr_b)
        begin
            mem_b[cb_reg[AW-1:0]] <= cmd_head.value;
        end
        rd_a_reg <= mem_a[addr_a];
        rd_b_reg <= mem_b[addr_b];
    end

endmodule

[hw/rtl/sorted_list_merge.sv]
// Sorted list merge block: two ascending lists of signed 32-bit values are
// loaded one word at a time and merged in ascending order on command.
//
// The input side is a queue: a word is taken when push is high and full is
// low. Opcode 0 appends to the first list, opcode 1 to the second, opcode 2
// merges; opcode 3 is taken and discarded. Appends to a full list are dropped.
// The result side is a queue too: while empty is low the oldest result word
// is on result, and pop takes it.
//
// A four-entry command queue separates the front from the back, so words are
// taken at one per cycle until it fills. A merge primes the store read ports
// and then emits its elements at one result per cycle while the receiver keeps
// taking them; a merge of two empty lists gives one word flagged empty_res.
// Both lists are empty again after a merge. With the queue empty and the back
// idle, the merge word passes through the command queue and the sequencer state
// before the first result word of the merge is registered in the result register.
//
// Reset empties the command queue and the result register and clears the list
// counts; store contents are not cleared. When the receiver stalls, the result
// register holds its word, the merge pauses and the command queue fills up.
module sorted_list_merge
    import slm_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic q_full, q_push, q_valid, q_pop;
    cmd_t q_cmd, q_head;

    // Decode of incoming words.
    slm_front u_front (
        .push   (push),
        .item   (item),
        .q_full (q_full),
        .full   (full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    // Command queue between front and back.
    slm_cmd_fifo u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_cmd (q_cmd),
        .full   (q_full),
        .rd_en  (q_pop),
        .valid  (q_valid),
        .head   (q_head)
    );

    // Stores and merge engine.
    slm_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_head  (q_head),
        .cmd_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

[hw/rtl/slm_checker.sv]
// Port-level checker for the sorted list merge block, bound to the top level.
// Depends on slm_pkg and on the port list of sorted_list_merge.
module slm_checker
    import slm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    push,
    input logic    full,
    input item_t   item,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // Merges accepted whose last result word has not yet been taken.
    logic [3:0] pending_reg;
    logic       merge_in, last_out;

    assign merge_in = push && !full && (item.opcode == OP_MERGE);
    assign last_out = pop && !empty && result.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (merge_in && !last_out)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (last_out && !merge_in)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // A result word only appears for a merge that was accepted earlier.
    a_result_needs_merge: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pending_reg != '0))
        else $error("result word without an outstanding merge");

    // A word flagged empty is the only word of its merge.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.empty_res) |-> result.last)
        else $error("empty result word not marked last");

    // A word flagged empty carries a zero value.
    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.empty_res) |-> (result.merged_value == '0))
        else $error("empty result word carries a value");

    // A waiting result word holds until it is taken.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result word changed");

endmodule

bind sorted_list_merge slm_checker u_slm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

[tb/tb_sorted_list_merge.sv]
// Testbench for sorted_list_merge: loads pairs of ascending lists, merges them and checks every
// result word against a queue-based merge kept here, under random idling on both sides.
// Depends on slm_pkg and the sorted_list_merge RTL.
module tb_sorted_list_merge
    import slm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH          = LIST_DEPTH_DEF;
    localparam int unsigned SETTLE_CYCLES  = 10;
    localparam int unsigned HOLD_OFF_LEN   = 300;

    // Value styles for generated lists.
    localparam int VAL_WIDE    = 0;
    localparam int VAL_NARROW  = 1;
    localparam int VAL_EXTREME = 2;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    logic    full;
    item_t   item = '0;
    logic    empty;
    logic    pop = 1'b0;
    result_t result;

    // Lists as the block should hold them, and the words it should emit.
    logic signed [VALUE_W-1:0] first_list[$];
    logic signed [VALUE_W-1:0] second_list[$];
    result_t                   expected_words[$];

    // Scratch lists for building one load sequence.
    logic signed [VALUE_W-1:0] seq_a[$];
    logic signed [VALUE_W-1:0] seq_b[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int fail_count = 0;
    int words_sent = 0;
    int merges_sent = 0;
    int words_checked = 0;

    sorted_list_merge u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Safety net against a hung run.
    initial
    begin
        #5_000_000;
        $display("FAIL sorted_list_merge");
        $finish;
    end

    // Update the list model for one accepted word and queue any merge output.
    task automatic predict_word(input logic [1:0] op, input logic signed [VALUE_W-1:0] v);
        int      i;
        int      j;
        int      n1;
        int      n2;
        int      k;
        logic    take_first;
        result_t w;
        begin
            i = 0;
            j = 0;
            k = 0;
            n1 = first_list.size();
            n2 = second_list.size();
            if (op == OP_PUSH_FIRST)
            begin
                if (n1 < DEPTH)
                    first_list.push_back(v);
            end
            else if (op == OP_PUSH_SECOND)
            begin
                if (n2 < DEPTH)
                    second_list.push_back(v);
            end
            else if (op == OP_MERGE)
            begin
                merges_sent++;
                if (n1 + n2 == 0)
                begin
                    w.merged_value = '0;
                    w.last = 1'b1;
                    w.empty_res = 1'b1;
                    expected_words.push_back(w);
                end
                else
                begin
                    // Strict compare: ties go to the second list.
                    while (i < n1 || j < n2)
                    begin
                        if (i >= n1)
                            take_first = 1'b0;
                        else if (j >= n2)
                            take_first = 1'b1;
                        else
                            take_first = (first_list[i] < second_list[j]);
                        if (take_first)
                        begin
                            w.merged_value = first_list[i];
                            i++;
                        end
                        else
                        begin
                            w.merged_value = second_list[j];
                            j++;
                        end
                        w.last = (k + 1 == n1 + n2);
                        w.empty_res = 1'b0;
                        expected_words.push_back(w);
                        k++;
                    end
                end
                first_list.delete();
                second_list.delete();
            end
        end
    endtask

    // Offer one word, with random idle cycles first, and wait until it is taken.
    // Push is left high on return; the next caller or the drain wait lowers it.
    task automatic send_word(input logic [1:0] op, input logic signed [VALUE_W-1:0] v);
        item_t w;
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
            w.opcode = op;
            w.value = v;
            push <= 1'b1;
            item <= w;
            @(posedge clk);
            while (full)
                @(posedge clk);
            predict_word(op, v);
            words_sent++;
        end
    endtask

    // Stop offering and wait for every expected word, then let the block settle.
    task automatic wait_results_drained();
        begin
            push <= 1'b0;
            @(posedge clk);
            while (expected_words.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES)
                @(posedge clk);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value(input int style);
        logic signed [VALUE_W-1:0] v;
        begin
            v = $urandom;
            if (style == VAL_NARROW)
                v = $signed($urandom_range(15)) - 8;
            else if (style == VAL_EXTREME)
            begin
                case ($urandom_range(3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = 32'sh0000_0000;
                    default: v = $urandom;
                endcase
            end
            return v;
        end
    endfunction

    // Build an ascending list by inserting each new value in place.
    task automatic fill_sorted(ref logic signed [VALUE_W-1:0] q[$], input int len,
                               input int style);
        int                        idx;
        logic signed [VALUE_W-1:0] v;
        begin
            q.delete();
            for (int n = 0; n < len; n++)
            begin
                v = random_value(style);
                idx = 0;
                while (idx < q.size() && q[idx] <= v)
                    idx++;
                q.insert(idx, v);
            end
        end
    endtask

    // Load two ascending lists with their appends interleaved at random and unused words mixed in, then merge.
    task automatic send_sorted_pair(input int len_a, input int len_b, input int style,
                                    input int noise_pct);
        int ia;
        int ib;
        begin
            ia = 0;
            ib = 0;
            fill_sorted(seq_a, len_a, style);
            fill_sorted(seq_b, len_b, style);
            while (ia < seq_a.size() || ib < seq_b.size())
            begin
                if ($urandom_range(99) < noise_pct)
                    send_word(OP_UNUSED, $urandom);
                if (ib >= seq_b.size() || (ia < seq_a.size() && $urandom_range(1) == 1))
                begin
                    send_word(OP_PUSH_FIRST, seq_a[ia]);
                    ia++;
                end
                else
                begin
                    send_word(OP_PUSH_SECOND, seq_b[ib]);
                    ib++;
                end
            end
            send_word(OP_MERGE, $urandom);
        end
    endtask

    function automatic int pick_len();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 70)
                return $urandom_range(6);
            else if (r < 95)
                return $urandom_range(16, 7);
            return $urandom_range(DEPTH + 2, DEPTH - 2);
        end
    endfunction

    // Receiver: random pop, or a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each taken result word with the oldest expected one.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: merged_value %0d last %0b empty_res %0b",
                       result.merged_value, result.last, result.empty_res);
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (result.merged_value !== want.merged_value)
                begin
                    $error("merged_value: expected %0d, got %0d",
                           want.merged_value, result.merged_value);
                    fail_count++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, result.last);
                    fail_count++;
                end
                if (result.empty_res !== want.empty_res)
                begin
                    $error("empty_res: expected %0b, got %0b", want.empty_res,
                           result.empty_res);
                    fail_count++;
                end
            end
        end
    end

    // Empty merges, value extremes, ties, one-sided lists and the unused opcode.
    task automatic test_directed();
        begin
            send_word(OP_MERGE, 32'sh0000_0000);
            send_word(OP_UNUSED, 32'sh7FFF_FFFF);
            send_word(OP_UNUSED, 32'sh8000_0000);
            send_word(OP_PUSH_FIRST, 32'sh8000_0000);
            send_word(OP_PUSH_SECOND, 32'sh8000_0000);
            send_word(OP_PUSH_FIRST, -32'sd1);
            send_word(OP_PUSH_SECOND, 32'sd7);
            send_word(OP_PUSH_FIRST, 32'sd0);
            send_word(OP_UNUSED, 32'sh5A5A_A5A5);
            send_word(OP_PUSH_FIRST, 32'sd7);
            send_word(OP_PUSH_SECOND, 32'sh7FFF_FFFF);
            send_word(OP_MERGE, 32'shFFFF_FFFF);
            send_word(OP_PUSH_FIRST, 32'sd3);
            send_word(OP_PUSH_FIRST, 32'sh7FFF_FFFF);
            send_word(OP_MERGE, 32'sh0000_0000);
            send_word(OP_PUSH_SECOND, 32'sh8000_0000);
            send_word(OP_PUSH_SECOND, 32'sd100);
            send_word(OP_MERGE, 32'sh0000_0000);
            send_word(OP_MERGE, 32'sh0000_0000);
            send_word(OP_PUSH_FIRST, 32'sd1);
            send_word(OP_PUSH_SECOND, 32'sd1);
            send_word(OP_MERGE, 32'sh0000_0000);
        end
    endtask

    // Both lists filled past capacity, then the first filled to capacity; extra appends must be dropped.
    task automatic test_list_overflow();
        begin
            send_sorted_pair(DEPTH + 2, DEPTH + 1, VAL_WIDE, 0);
            send_sorted_pair(DEPTH, 1, VAL_NARROW, 0);
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering words.
    task automatic test_backpressure();
        begin
            hold_left = HOLD_OFF_LEN;
            repeat (4)
                send_sorted_pair(5, 5, VAL_WIDE, 0);
        end
    endtask

    // Mostly well-formed load-and-merge sequences, with unsorted loads and noise mixed in.
    task automatic test_random(input int n_words);
        int start;
        int r;
        begin
            start = words_sent;
            while (words_sent - start < n_words)
            begin
                r = $urandom_range(99);
                if (r < 85)
                    send_sorted_pair(pick_len(), pick_len(), $urandom_range(2), 8);
                else if (r < 95)
                begin
                    repeat ($urandom_range(6, 1))
                        send_word($urandom_range(1) ? OP_PUSH_FIRST : OP_PUSH_SECOND,
                                  $urandom);
                    if ($urandom_range(1) == 1)
                        send_word(OP_MERGE, $urandom);
                end
                else
                    send_word($urandom_range(1) ? OP_UNUSED : OP_MERGE, $urandom);
            end
        end
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 59;
        test_directed();
        wait_results_drained();
        test_list_overflow();
        wait_results_drained();
        test_backpressure();
        wait_results_drained();
        test_random(90);
        wait_results_drained();

        send_idle_pct = 59;
        recv_idle_pct = 30;
        test_random(90);
        wait_results_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(90);
        wait_results_drained();

        $display("Run covered %0d input words and %0d merges, %0d result words checked,",
                 words_sent, merges_sent, words_checked);
        $display("including overflowing lists, a long receiver hold-off and three idle mixes.");
        if (fail_count == 0)
            $display("PASS sorted_list_merge");
        else
            $display("FAIL sorted_list_merge");
        $finish;
    end

endmodule
